// ===== design/cht_pkg.sv =====
// Shared types and constants for the connection handle table.
package cht_pkg;

  localparam int HANDLE_W = 32;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  // One table entry: the used flag above the stored handle.
  localparam int ENTRY_W  = HANDLE_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [HANDLE_W-1:0]  handle;
    logic [SLOT_W-1:0]    slot;
    logic                 grew;
    logic [COUNT_W-1:0]   used;
    logic [COUNT_W-1:0]   length;
  } result_t;

endpackage

// ===== design/connection_handle_table.sv =====
// Top level of the connection handle table: entry RAM, sequencer and output register.
//
//   Channel  Direction  Handshake           Payload
//   in_      request    in_valid/in_stall   in_operation, in_handle
//   out_     result     out_valid/out_stall out_status, out_result_handle, out_slot_index,
//                                           out_table_grew, out_used_count, out_active_length
//
// After reset the block sweeps the entry RAM once, one entry per cycle, and accepts no
// request before the sweep has ended.
// A lookup or free goes through three steps: accept, RAM read and check, hand-off to the output.
// A lookup or free of handle zero, or of a slot beyond the active length, skips the RAM
// read and check and goes straight from accept to the hand-off.
// An allocate reads one slot at a time from the slot after the last handle up to the active
// length, and once more from slot 0 when the scan wraps; the single RAM read port sets that pace.
// The output register lets a new request enter while the previous result is still stalled.
module connection_handle_table #(
  parameter int TABLE_SLOTS = 1024,
  parameter int INIT_SLOTS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cht_pkg::OP_W-1:0]      in_operation,
  input  logic [cht_pkg::HANDLE_W-1:0]  in_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cht_pkg::STATUS_W-1:0]  out_status,
  output logic [cht_pkg::HANDLE_W-1:0]  out_result_handle,
  output logic [cht_pkg::SLOT_W-1:0]    out_slot_index,
  output logic                          out_table_grew,
  output logic [cht_pkg::COUNT_W-1:0]   out_used_count,
  output logic [cht_pkg::COUNT_W-1:0]   out_active_length
);

  import cht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  // Each RAM entry holds a used flag above the full handle stored in that slot.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               res_valid;
  logic               res_take;
  result_t            res;

  logic               out_valid_r, out_valid_nxt;
  result_t            out_r;

  cht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cht_engine #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .INIT_SLOTS  (INIT_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (op_t'(in_operation)),
    .in_handle (in_handle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // A finished result moves into the output register whenever that register is empty
  // or its current result is being taken in the same cycle.
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_result_handle = out_r.handle;
  assign out_slot_index    = out_r.slot;
  assign out_table_grew    = out_r.grew;
  assign out_used_count    = out_r.used;
  assign out_active_length = out_r.length;

endmodule

// ===== design/cht_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cht_engine.sv =====
// Sequencer for the handle table: clearing pass, lookup, free and allocate scan.
module cht_engine #(
  parameter int TABLE_SLOTS = 1024,
  parameter int INIT_SLOTS  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cht_pkg::op_t                      in_op,
  input  logic [cht_pkg::HANDLE_W-1:0]      in_handle,
  output logic                              res_valid,
  input  logic                              res_take,
  output cht_pkg::result_t                  res,
  output logic                              ram_we,
  output logic [$clog2(TABLE_SLOTS)-1:0]    ram_waddr,
  output logic [cht_pkg::ENTRY_W-1:0]       ram_wdata,
  output logic [$clog2(TABLE_SLOTS)-1:0]    ram_raddr,
  input  logic [cht_pkg::ENTRY_W-1:0]       ram_rdata
);

  import cht_pkg::*;

  localparam int IDX_W     = $clog2(TABLE_SLOTS);
  localparam int LEN_W     = IDX_W + 1;
  localparam int HI_W      = HANDLE_W - IDX_W;
  localparam int START_LEN = (INIT_SLOTS < TABLE_SLOTS) ? INIT_SLOTS : TABLE_SLOTS;
  localparam int HALF_LEN  = TABLE_SLOTS / 2;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [HANDLE_W-1:0]  h_r, h_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     used_r, used_nxt;
  logic [HANDLE_W-1:0]  last_r, last_nxt;
  logic [LEN_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic                 wrap_r, wrap_nxt;
  logic [IDX_W-1:0]     clr_addr_r, clr_addr_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0]  res_handle_r, res_handle_nxt;
  logic [IDX_W-1:0]     res_slot_r, res_slot_nxt;
  logic                 res_grew_r, res_grew_nxt;

  logic [HANDLE_W-1:0]  next_h;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     h_idx;
  logic [HI_W-1:0]      hi_sel;
  logic                 entry_used;
  logic                 hit;
  logic                 found;
  logic [HANDLE_W-1:0]  take_h;
  logic [IDX_W-1:0]     take_idx;

  assign next_h     = last_r + HANDLE_W'(1);
  assign in_idx     = in_handle[IDX_W-1:0];
  assign h_idx      = h_r[IDX_W-1:0];
  assign entry_used = ram_rdata[HANDLE_W];
  assign hit        = entry_used && (ram_rdata[HANDLE_W-1:0] == h_r);
  assign found      = chk_vld_r && !entry_used;
  // The second pass moves the handle to the next multiple of the table size.
  assign hi_sel     = wrap_r ? (h_r[HANDLE_W-1:IDX_W] + HI_W'(1)) : h_r[HANDLE_W-1:IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      len_r       <= LEN_W'(START_LEN);
      used_r      <= '0;
      last_r      <= '0;
      clr_addr_r  <= '0;
      chk_vld_r   <= 1'b0;
      wrap_r      <= 1'b0;
      scan_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      used_r      <= used_nxt;
      last_r      <= last_nxt;
      clr_addr_r  <= clr_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      wrap_r      <= wrap_nxt;
      scan_addr_r <= scan_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    h_r          <= h_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_slot_r   <= res_slot_nxt;
    res_grew_r   <= res_grew_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    h_nxt          = h_r;
    len_nxt        = len_r;
    used_nxt       = used_r;
    last_nxt       = last_r;
    scan_addr_nxt  = scan_addr_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    wrap_nxt       = wrap_r;
    clr_addr_nxt   = clr_addr_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_slot_nxt   = res_slot_r;
    res_grew_nxt   = res_grew_r;
    in_stall       = 1'b1;
    res_valid      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    take_h         = '0;
    take_idx       = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == IDX_W'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = in_idx;
        if (in_valid) begin
          op_nxt         = in_op;
          res_status_nxt = ST_NOT_FOUND;
          res_handle_nxt = '0;
          res_slot_nxt   = '0;
          res_grew_nxt   = 1'b0;
          case (in_op)
            OP_LOOKUP, OP_FREE: begin
              h_nxt = in_handle;
              if (in_handle == '0 || {1'b0, in_idx} >= len_r) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_LOOK;
              end
            end
            OP_ALLOC: begin
              h_nxt         = next_h;
              scan_addr_nxt = {1'b0, next_h[IDX_W-1:0]};
              chk_vld_nxt   = 1'b0;
              wrap_nxt      = 1'b0;
              state_nxt     = S_SCAN;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_LOOK: begin
        if (hit) begin
          res_status_nxt = ST_OK;
          res_handle_nxt = h_r;
          res_slot_nxt   = h_idx;
          if (op_r == OP_FREE) begin
            ram_we    = 1'b1;
            ram_waddr = h_idx;
            used_nxt  = used_r - LEN_W'(1);
          end
        end
        state_nxt = S_RESP;
      end

      S_SCAN: begin
        if (found) begin
          take_idx = chk_idx_r;
          take_h   = {hi_sel, chk_idx_r};
        end else if (scan_addr_r < len_r) begin
          ram_raddr     = scan_addr_r[IDX_W-1:0];
          chk_idx_nxt   = scan_addr_r[IDX_W-1:0];
          chk_vld_nxt   = 1'b1;
          scan_addr_nxt = scan_addr_r + LEN_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          if (wrap_r) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end else if (used_r < (len_r >> 1) || len_r > LEN_W'(HALF_LEN)) begin
            wrap_nxt      = 1'b1;
            scan_addr_nxt = '0;
          end else begin
            // Grow: the first slot of the new upper half is taken.
            take_idx     = len_r[IDX_W-1:0];
            take_h       = {h_r[HANDLE_W-1:IDX_W], len_r[IDX_W-1:0]};
            len_nxt      = len_r << 1;
            res_grew_nxt = 1'b1;
          end
        end
        if (found || (scan_addr_r >= len_r && !wrap_r && !(used_r < (len_r >> 1))
                      && !(len_r > LEN_W'(HALF_LEN)))) begin
          ram_we         = 1'b1;
          ram_waddr      = take_idx;
          ram_wdata      = {1'b1, take_h};
          used_nxt       = used_r + LEN_W'(1);
          last_nxt       = take_h;
          res_status_nxt = ST_OK;
          res_handle_nxt = take_h;
          res_slot_nxt   = take_idx;
          state_nxt      = S_RESP;
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status = res_status_r;
    res.handle = res_handle_r;
    res.slot   = SLOT_W'(res_slot_r);
    res.grew   = res_grew_r;
    res.used   = COUNT_W'(used_r);
    res.length = COUNT_W'(len_r);
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the connection handle table: random requests against a shadow table.
`timescale 1ns / 1ps

module tb_top;
  import cht_pkg::*;

  localparam int TABLE_SLOTS = 1024;
  localparam int INIT_SLOTS  = 64;

  // The fourth operation code has no meaning; the block must answer it with not found.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int RANDOM_REQS  = 700;
  localparam int IDLE_PCT     = 15;
  // A full allocate at the largest length reads each slot at most twice, and the
  // clearing sweep after reset writes every slot once. The limit is set well above both.
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  // Neither side idles inside this window, given in ns.
  localparam longint STEADY_FROM = 25000;
  localparam longint STEADY_TO   = 50000;

  typedef struct packed {
    logic [OP_W-1:0]     code;
    logic [HANDLE_W-1:0] hdl;
  } req_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = '0;
  logic [HANDLE_W-1:0] in_handle    = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_result_handle;
  logic [SLOT_W-1:0]   out_slot_index;
  logic                out_table_grew;
  logic [COUNT_W-1:0]  out_used_count;
  logic [COUNT_W-1:0]  out_active_length;

  connection_handle_table #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .INIT_SLOTS (INIT_SLOTS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_handle(out_result_handle),
    .out_slot_index   (out_slot_index),
    .out_table_grew   (out_table_grew),
    .out_used_count   (out_used_count),
    .out_active_length(out_active_length)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table. It advances once per accepted request, in acceptance order.
  bit                  shadow_used  [TABLE_SLOTS];
  logic [HANDLE_W-1:0] shadow_owner [TABLE_SLOTS];
  int unsigned         shadow_len   = (INIT_SLOTS < TABLE_SLOTS) ? INIT_SLOTS : TABLE_SLOTS;
  int unsigned         shadow_count = 0;
  logic [HANDLE_W-1:0] shadow_last  = '0;
  int unsigned         full_replies = 0;

  req_t                queued_reqs[$];
  result_t             pending_replies[$];
  // Handles the shadow table holds now, and some it held once. The request
  // generator draws lookup and free targets from these.
  logic [HANDLE_W-1:0] live_handles[$];
  logic [HANDLE_W-1:0] retired_handles[$];
  int                  mismatches = 0;

  function automatic bit steady_window();
    return ($time >= STEADY_FROM) && ($time < STEADY_TO);
  endfunction

  // A handle is known only when it sits in its own slot, inside the active length.
  function automatic bit owner_slot(input logic [HANDLE_W-1:0] h, output int unsigned idx);
    idx = h % TABLE_SLOTS;
    if (h == '0 || idx >= shadow_len) return 1'b0;
    return shadow_used[idx] && (shadow_owner[idx] == h);
  endfunction

  function automatic void claim_slot(int unsigned idx, logic [HANDLE_W-1:0] h);
    shadow_used[idx]  = 1'b1;
    shadow_owner[idx] = h;
    shadow_count++;
    shadow_last = h;
    live_handles.push_back(h);
  endfunction

  function automatic void release_slot(int unsigned idx);
    int pos;
    pos = -1;
    shadow_used[idx] = 1'b0;
    shadow_count--;
    for (int k = 0; k < live_handles.size(); k++) begin
      if (pos < 0 && live_handles[k] == shadow_owner[idx]) pos = k;
    end
    if (pos >= 0) live_handles.delete(pos);
    retired_handles.push_back(shadow_owner[idx]);
    if (retired_handles.size() > 64) void'(retired_handles.pop_front());
  endfunction

  // Allocation: scan up from the slot after the last handle; when nothing is free,
  // either wrap to the next multiple of the table size or double the active length.
  function automatic result_t allocate_reply();
    result_t             r;
    logic [HANDLE_W-1:0] nxt;
    logic [HANDLE_W-1:0] base;
    int unsigned         first;
    int unsigned         i;
    bit                  done;
    r = '0;
    r.status = ST_OK;
    done = 1'b0;
    nxt = shadow_last + 32'd1;
    first = nxt % TABLE_SLOTS;
    for (i = first; i < shadow_len && !done; i++) begin
      if (!shadow_used[i]) begin
        r.handle = nxt + (i - first);
        r.slot   = SLOT_W'(i);
        claim_slot(i, r.handle);
        done = 1'b1;
      end
    end
    if (!done) begin
      if (shadow_count < shadow_len / 2 || shadow_len * 2 > TABLE_SLOTS) begin
        // Wrap. The base is taken modulo 2^32 like every other handle sum.
        base = (nxt / TABLE_SLOTS + 1) * TABLE_SLOTS;
        for (i = 0; i < shadow_len && !done; i++) begin
          if (!shadow_used[i]) begin
            r.handle = base + i;
            r.slot   = SLOT_W'(i);
            claim_slot(i, r.handle);
            done = 1'b1;
          end
        end
        if (!done) begin
          // Table full: nothing changes, and the handle increment is dropped.
          r.status = ST_FULL;
          full_replies++;
        end
      end else begin
        for (i = shadow_len; i < 2 * shadow_len; i++) shadow_used[i] = 1'b0;
        r.handle = nxt + (shadow_len - first);
        r.slot   = SLOT_W'(shadow_len);
        claim_slot(shadow_len, r.handle);
        shadow_len = shadow_len * 2;
        r.grew = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic result_t expected_reply(logic [OP_W-1:0] code, logic [HANDLE_W-1:0] h);
    result_t     r;
    int unsigned idx;
    r = '0;
    r.status = ST_NOT_FOUND;
    case (code)
      OP_LOOKUP: begin
        if (owner_slot(h, idx)) begin
          r.status = ST_OK;
          r.handle = h;
          r.slot   = SLOT_W'(idx);
        end
      end
      OP_ALLOC: begin
        r = allocate_reply();
      end
      OP_FREE: begin
        if (owner_slot(h, idx)) begin
          release_slot(idx);
          r.status = ST_OK;
          r.handle = h;
          r.slot   = SLOT_W'(idx);
        end
      end
      default: begin
      end
    endcase
    if (r.status != ST_OK) begin
      r.handle = '0;
      r.slot   = '0;
    end
    r.used   = COUNT_W'(shadow_count);
    r.length = COUNT_W'(shadow_len);
    return r;
  endfunction

  // Lookup and free targets: mostly live handles, then stale ones, handles that
  // share a live slot but not its owner, random words, zero, and small handles
  // whose slot may lie beyond the active length.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70 && live_handles.size() != 0)
      return live_handles[$urandom_range(0, live_handles.size() - 1)];
    if (roll < 80 && retired_handles.size() != 0)
      return retired_handles[$urandom_range(0, retired_handles.size() - 1)];
    if (roll < 88 && live_handles.size() != 0)
      return live_handles[$urandom_range(0, live_handles.size() - 1)] ^
             (32'($urandom_range(1, 4194303)) << SLOT_W);
    if (roll < 95) return $urandom();
    if (roll < 97) return '0;
    return 32'($urandom_range(1, TABLE_SLOTS - 1));
  endfunction

  task automatic enqueue(logic [OP_W-1:0] code, logic [HANDLE_W-1:0] h);
    queued_reqs.push_back('{code, h});
  endtask

  // The generator works on falling edges, so it never races the driver.
  task automatic wait_for_room(int depth);
    while (queued_reqs.size() >= depth) @(negedge clk);
  endtask

  // Sender. A request that is offered stays unchanged until it is accepted;
  // after an acceptance or an idle cycle the next request may be offered.
  always @(posedge clk) begin : request_driver
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (queued_reqs.size() != 0 && (steady_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = queued_reqs.pop_front();
        in_valid     <= 1'b1;
        in_operation <= nxt.code;
        in_handle    <= nxt.hdl;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Besides random stalls it holds off once for a long stretch, while
  // the sender keeps offering, so the block fills up and stalls its input.
  int rx_cycles = 0;
  int hold_left = 0;

  always @(posedge clk) begin : result_receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (rx_cycles == HOLD_START) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else begin
        out_stall <= !steady_window() && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Scoreboard. Accepted requests are predicted first, then an accepted result
  // is compared with the oldest prediction, field by field.
  always @(posedge clk) begin : reply_checker
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        pending_replies.push_back(expected_reply(in_operation, in_handle));
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("result with no request pending: status %0d handle %0h",
                 out_status, out_result_handle);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (out_status != want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_result_handle != want.handle) begin
            $error("out_result_handle: expected %0h, got %0h", want.handle, out_result_handle);
            mismatches++;
          end
          if (out_slot_index != want.slot) begin
            $error("out_slot_index: expected %0d, got %0d", want.slot, out_slot_index);
            mismatches++;
          end
          if (out_table_grew != want.grew) begin
            $error("out_table_grew: expected %0d, got %0d", want.grew, out_table_grew);
            mismatches++;
          end
          if (out_used_count != want.used) begin
            $error("out_used_count: expected %0d, got %0d", want.used, out_used_count);
            mismatches++;
          end
          if (out_active_length != want.length) begin
            $error("out_active_length: expected %0d, got %0d", want.length, out_active_length);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without a handshake on either channel.
  int dead_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int               issued;
    int               burst;
    int unsigned      kind;
    logic [OP_W-1:0]  code;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on a fresh table: handle zero, all ones, the spare code,
    // the first allocations, a handle that shares a slot with a live one but is
    // not its owner, a slot beyond the active length, and a double free.
    enqueue(OP_LOOKUP, '0);
    enqueue(OP_FREE, '0);
    enqueue(OP_LOOKUP, '1);
    enqueue(OP_SPARE, 32'h5A5A_A5A5);
    enqueue(OP_ALLOC, '1);
    enqueue(OP_ALLOC, '0);
    enqueue(OP_ALLOC, 32'hDEAD_BEEF);
    enqueue(OP_LOOKUP, 32'd1);
    enqueue(OP_LOOKUP, 32'd1025);
    enqueue(OP_LOOKUP, 32'hFFFF_FC01);
    enqueue(OP_LOOKUP, 32'd100);
    enqueue(OP_FREE, 32'd2);
    enqueue(OP_FREE, 32'd2);
    enqueue(OP_LOOKUP, 32'd2);
    enqueue(OP_ALLOC, 32'h0000_0002);
    enqueue(OP_LOOKUP, 32'd4);
    enqueue(OP_FREE, '1);
    enqueue(OP_SPARE, '1);
    enqueue(OP_LOOKUP, 32'd3);
    enqueue(OP_FREE, 32'd3);
    enqueue(OP_LOOKUP, 32'h8000_0000);

    // Random part, built from bursts: runs of allocations push the scan to the
    // end of the active length, where it wraps or grows; runs of frees and
    // lookups work on live handles, with noise mixed in.
    issued = 0;
    while (issued < RANDOM_REQS) begin
      wait_for_room(16);
      kind = $urandom_range(0, 99);
      if (kind < 35) burst = $urandom_range(1, 24);
      else if (kind < 95) burst = $urandom_range(1, 12);
      else burst = $urandom_range(1, 4);
      for (int n = 0; n < burst; n++) begin
        if (kind < 35) code = OP_ALLOC;
        else if (kind < 55) code = OP_FREE;
        else if (kind < 80) code = OP_LOOKUP;
        else if (kind < 95) code = 2'($urandom_range(OP_LOOKUP, OP_FREE));
        else code = 2'($urandom_range(0, 3));
        if (code == OP_ALLOC || kind >= 95) enqueue(code, $urandom());
        else enqueue(code, pick_handle());
      end
      issued += burst;
    end

    // Fill the table to its largest length and beyond, so that allocation
    // reports a full table a few times.
    while (full_replies < 3 && issued < 3000) begin
      wait_for_room(8);
      repeat (8) enqueue(OP_ALLOC, $urandom());
      if ($urandom_range(0, 3) == 0) enqueue(OP_LOOKUP, pick_handle());
      issued += 8;
    end

    // Punch holes into the full table and allocate again: at the largest length
    // allocation cannot grow, so it wraps around when its scan finds no hole.
    for (int n = 0; n < 120; n++) begin
      wait_for_room(16);
      kind = $urandom_range(0, 99);
      if (kind < 40) enqueue(OP_FREE, pick_handle());
      else if (kind < 70) enqueue(OP_LOOKUP, pick_handle());
      else enqueue(OP_ALLOC, $urandom());
    end

    while (queued_reqs.size() != 0 || in_valid) @(negedge clk);
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cht_pkg.sv
design/cht_ram.sv
design/cht_engine.sv
design/connection_handle_table.sv
dv/tb_top.sv
